### design/ptw_pkg.sv
// Package for the four-level page table engine.
// Holds operation, status and register index codes plus shared types.
// No dependencies.
package ptw_pkg;

	localparam int TABLE_FRAMES_DEF = 16;
	localparam int WORDS_PER_FRAME  = 512;
	localparam int PFN_W            = 40;

	// operations
	localparam logic [1:0] OP_TRANSLATE = 2'd0;
	localparam logic [1:0] OP_MAP       = 2'd1;
	localparam logic [1:0] OP_UNMAP     = 2'd2;
	localparam logic [1:0] OP_WRITE     = 2'd3;

	// result status
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_UNMAPPED = 3'd1;
	localparam logic [2:0] ST_HUGE     = 3'd2;
	localparam logic [2:0] ST_MAPPED   = 3'd3;
	localparam logic [2:0] ST_NOFRAME  = 3'd4;
	localparam logic [2:0] ST_OUTSIDE  = 3'd5;

	// configuration register indexes
	localparam logic [1:0] REG_STORE_BASE = 2'd0;
	localparam logic [1:0] REG_ROOT       = 2'd1;
	localparam logic [1:0] REG_FIRST_FREE = 2'd2;

	// result of the shared frame range check
	typedef struct packed {
		logic             ok;
		logic [PFN_W-1:0] rel;
	} frm_chk_t;

endpackage

### design/ptw_store.sv
// Table store: single-port memory with registered read data.
// Depends on nothing but its parameters.
module ptw_store #(
	parameter int DEPTH  = 8192,
	parameter int ADDR_W = 13
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] addr,
	input  logic [63:0]       wdata,
	output logic [63:0]       rdata
);
	logic [63:0] mem [0:DEPTH-1];
	logic [63:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
endmodule

### design/ptw_frame_unit.sv
// Shared frame check: subtract the store base from a pointer frame number
// and compare against the store size. Uses ptw_pkg.
module ptw_frame_unit
	import ptw_pkg::*;
#(
	parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
) (
	input  logic [PFN_W-1:0] pfn,
	input  logic [PFN_W-1:0] base,
	output frm_chk_t         chk
);
	logic [PFN_W:0] diff;

	assign diff    = {1'b0, pfn} - {1'b0, base};
	assign chk.rel = diff[PFN_W-1:0];
	assign chk.ok  = !diff[PFN_W] && (diff[PFN_W-1:0] < PFN_W'(TABLE_FRAMES));
endmodule

### design/four_level_page_table_engine_unit.sv
// Top level of the four-level page table engine.
// Uses ptw_pkg, ptw_store and ptw_frame_unit.
//
// Channel   | Dir | Handshake               | Payload
// s_axis    | in  | tvalid/tready           | tdata: virt_addr, phys_addr, page_flags,
//           |     |                         |   no_exec, word_index, word_data
//           |     |                         | tuser: operation
// m_axis    | out | tvalid/tready           | tdata: status, phys_result
// cfg       | in  | cfg_wr_en, no wait      | cfg_index, cfg_wdata
//
// Each level passes through a read state and an evaluate state on the single
// store port, plus a write state per entry written.
// After reset a clearing pass zeroes the store, during which no transaction
// is accepted (configuration writes still land).
// A finished result waits in the output register; the next transaction is
// accepted meanwhile and stalls only at its own result.
module four_level_page_table_engine_unit
	import ptw_pkg::*;
#(
	parameter int TABLE_FRAMES = TABLE_FRAMES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [47:0] virt_addr, [99:48] phys_addr, [111:100] page_flags,
	// [112] no_exec, [125:113] word_index, [189:126] word_data, [191:190] zero
	input  logic [191:0] s_axis_tdata,
	// [1:0] operation
	input  logic [1:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [2:0] status, [54:3] phys_result, [55] zero
	output logic [55:0]  m_axis_tdata,
	input  logic         cfg_wr_en,
	input  logic [1:0]   cfg_index,
	input  logic [39:0]  cfg_wdata
);
	localparam int FW      = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
	localparam int DEPTH   = TABLE_FRAMES * WORDS_PER_FRAME;
	localparam int ADDR_W  = FW + 9;
	localparam int AW      = $clog2(TABLE_FRAMES + 1);
	localparam int CW      = 12;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CLEAR = 3'd1;
	localparam logic [2:0] S_RD    = 3'd2;
	localparam logic [2:0] S_EV    = 3'd3;
	localparam logic [2:0] S_WR    = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [39:0]       base_q;
	logic [3:0]        root_q;
	logic [4:0]        ffree_q;
	logic [AW-1:0]     alloc_q;

	logic [1:0]        op_q;
	logic [47:0]       va_q;
	logic [51:0]       pa_q;
	logic [11:0]       flags_q;
	logic              nx_q;
	logic [FW-1:0]     frame_q;
	logic [1:0]        lvl_q;
	logic [ADDR_W-1:0] waddr_q;
	logic [63:0]       wdata_q;
	logic              fin_q;
	logic [2:0]        st_q;
	logic [51:0]       res_q;

	logic              out_valid_q;
	logic [2:0]        out_status_q;
	logic [51:0]       out_pa_q;

	logic [1:0]        in_op;
	logic [12:0]       in_wi;
	logic              accept;
	logic [8:0]        ix_sel;
	logic [ADDR_W-1:0] cur_addr;
	logic [ADDR_W-1:0] mem_addr;
	logic              mem_we;
	logic [63:0]       mem_wdata;
	logic [63:0]       ent;
	frm_chk_t          chk;
	logic [CW-1:0]     nf;
	logic              nf_ok;
	logic [39:0]       new_pfn;

	assign in_op  = s_axis_tuser;
	assign in_wi  = s_axis_tdata[125:113];
	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);

	// pick the table index for the current level
	always_comb begin
		unique case (lvl_q)
			2'd0:    ix_sel = va_q[47:39];
			2'd1:    ix_sel = va_q[38:30];
			2'd2:    ix_sel = va_q[29:21];
			default: ix_sel = va_q[20:12];
		endcase
	end
	assign cur_addr = {frame_q, ix_sel};

	// store port: clearing sweep, walk reads, and entry writes
	always_comb begin
		mem_we    = 1'b0;
		mem_addr  = cur_addr;
		mem_wdata = wdata_q;
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = '0;
			end
			S_WR: begin
				mem_we   = 1'b1;
				mem_addr = waddr_q;
			end
			default: mem_addr = cur_addr;
		endcase
	end

	ptw_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (ent)
	);

	ptw_frame_unit #(.TABLE_FRAMES(TABLE_FRAMES)) u_frame (
		.pfn  (ent[51:12]),
		.base (base_q),
		.chk  (chk)
	);

	// bump allocator candidate
	assign nf      = CW'(ffree_q) + CW'(alloc_q);
	assign nf_ok   = nf < CW'(TABLE_FRAMES);
	assign new_pfn = base_q + 40'(nf);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			root_q  <= '0;
			ffree_q <= 5'd1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_STORE_BASE: base_q  <= cfg_wdata;
				REG_ROOT:       root_q  <= cfg_wdata[3:0];
				REG_FIRST_FREE: ffree_q <= cfg_wdata[4:0];
				default:        ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			alloc_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// drop a taken result unless the result state reloads it this cycle
			if (m_axis_tvalid && m_axis_tready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q    <= in_op;
						va_q    <= s_axis_tdata[47:0];
						pa_q    <= s_axis_tdata[99:48];
						flags_q <= s_axis_tdata[111:100];
						nx_q    <= s_axis_tdata[112];
						lvl_q   <= 2'd0;
						frame_q <= FW'(root_q);
						res_q   <= '0;
						if (in_op == OP_WRITE) begin
							if (20'(in_wi) < 20'(DEPTH)) begin
								waddr_q <= ADDR_W'(in_wi);
								wdata_q <= s_axis_tdata[189:126];
								fin_q   <= 1'b1;
								st_q    <= ST_OK;
								state_q <= S_WR;
							end else begin
								st_q    <= ST_OUTSIDE;
								state_q <= S_OUT;
							end
						end else if (11'(root_q) >= 11'(TABLE_FRAMES)) begin
							st_q    <= ST_OUTSIDE;
							state_q <= S_OUT;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: state_q <= S_EV;
				S_EV: begin
					state_q <= S_OUT;
					case (op_q)
						OP_TRANSLATE: begin
							if (!ent[0]) begin
								st_q <= ST_UNMAPPED;
							end else if (lvl_q == 2'd1 && ent[7]) begin
								st_q  <= ST_OK;
								res_q <= {ent[51:30], va_q[29:0]};
							end else if (lvl_q == 2'd2 && ent[7]) begin
								st_q  <= ST_OK;
								res_q <= {ent[51:21], va_q[20:0]};
							end else if (lvl_q == 2'd3) begin
								st_q  <= ST_OK;
								res_q <= {ent[51:12], va_q[11:0]};
							end else if (!chk.ok) begin
								st_q <= ST_OUTSIDE;
							end else begin
								frame_q <= FW'(chk.rel);
								lvl_q   <= lvl_q + 2'd1;
								state_q <= S_RD;
							end
						end
						OP_MAP: begin
							if (lvl_q == 2'd3) begin
								if (ent[0]) begin
									st_q <= ST_MAPPED;
								end else begin
									waddr_q <= cur_addr;
									wdata_q <= {nx_q, 11'd0, pa_q[51:12], flags_q[11:1], 1'b1};
									fin_q   <= 1'b1;
									st_q    <= ST_OK;
									state_q <= S_WR;
								end
							end else if (ent[0]) begin
								if (lvl_q != 2'd0 && ent[7]) begin
									st_q <= ST_HUGE;
								end else if (!chk.ok) begin
									st_q <= ST_OUTSIDE;
								end else begin
									frame_q <= FW'(chk.rel);
									lvl_q   <= lvl_q + 2'd1;
									state_q <= S_RD;
								end
							end else if (!nf_ok) begin
								st_q <= ST_NOFRAME;
							end else begin
								// install a fresh table pointer, then descend into it
								alloc_q <= alloc_q + 1'b1;
								waddr_q <= cur_addr;
								wdata_q <= {12'd0, new_pfn, 12'h003};
								fin_q   <= 1'b0;
								frame_q <= FW'(nf);
								lvl_q   <= lvl_q + 2'd1;
								state_q <= S_WR;
							end
						end
						OP_UNMAP: begin
							if (lvl_q == 2'd3) begin
								waddr_q <= cur_addr;
								wdata_q <= '0;
								fin_q   <= 1'b1;
								st_q    <= ST_OK;
								state_q <= S_WR;
							end else if (!ent[0]) begin
								st_q <= ST_UNMAPPED;
							end else if (lvl_q != 2'd0 && ent[7]) begin
								st_q <= ST_HUGE;
							end else if (!chk.ok) begin
								st_q <= ST_OUTSIDE;
							end else begin
								frame_q <= FW'(chk.rel);
								lvl_q   <= lvl_q + 2'd1;
								state_q <= S_RD;
							end
						end
						default: st_q <= ST_OUTSIDE;
					endcase
				end
				S_WR: state_q <= fin_q ? S_OUT : S_RD;
				S_OUT: begin
					// hold until the output register is free
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= st_q;
						out_pa_q     <= res_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_pa_q, out_status_q};

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("transaction accepted while busy");
	a_alloc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(alloc_q) <= TABLE_FRAMES)
		else $error("allocator ran past the store");
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == S_OUT))
		else $error("result raised outside the result state");
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == S_WR || state_q == S_CLEAR))
		else $error("store written outside a write cycle");
`endif

endmodule
